// ----- hw/rtl/stsd_pkg.sv -----
// package for the sorted key table with search and delete
// holds the controller state type, result codes and the cell control bundle
// no dependencies
`default_nettype none

package stsd_pkg;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // operation codes carried in the input item
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result codes
  localparam logic [1:0] RC_NOT_FOUND = 2'd0;
  localparam logic [1:0] RC_DELETED   = 2'd1;
  localparam logic [1:0] RC_NOW_EMPTY = 2'd2;
  localparam logic [1:0] RC_FULL      = 2'd3;

  // strobes broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;   // compare the broadcast key and hold the flags
    logic ins_en;   // open a slot and insert the broadcast key
    logic del_en;   // close the gap at the first matching entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_table_search_delete.sv -----
// sorted key table: load inserts in order, query deletes one matching copy
// result: registered as the controller leaves the exec state, which waits
//   while an earlier result item is still held; a new input item is taken
//   only in the idle state, after the shift through the row of cells
// reset: entry count and controller cleared; stored keys stay unset until loaded
// depends on stsd_pkg and stsd_cell
`default_nettype none

module sorted_table_search_delete
  import stsd_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 18,
  localparam int CW         = $clog2(TABLE_DEPTH + 1),
  localparam int IN_W       = ((1 + KEY_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((2 + CW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input item
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // operation, key_value
  // result item
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // result_code, live_count
);

  state_t               state_r;
  state_t               state_nxt;
  logic                 op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [1:0]           out_code_r;
  logic [1:0]           out_code_nxt;
  logic [CW-1:0]        out_count_r;

  logic                 accept;
  logic                 done;
  logic                 full;
  logic                 hit;
  logic [KEY_WIDTH-1:0] in_key;
  logic [KEY_WIDTH-1:0] key_bcast;
  cell_ctrl_t           ctrl;

  logic [KEY_WIDTH-1:0] cell_key [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_le;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [TABLE_DEPTH-1:0] cell_live;

  // handshake and broadcast key
  assign in_key    = in_tdata[KEY_WIDTH:1];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign done      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign key_bcast = (state_r == ST_IDLE) ? in_key : key_r;
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign hit       = |cell_eq;

  assign ctrl.cmp_en = accept;
  assign ctrl.ins_en = done && (op_r == OP_LOAD) && !full;
  assign ctrl.del_en = done && (op_r == OP_QUERY) && hit;

  // row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_le;
    logic [KEY_WIDTH-1:0] right_key;

    assign cell_live[i] = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign left_key = key_bcast;
      assign left_le  = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_le  = cell_le[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_key = key_bcast;
    end else begin : g_lower
      assign right_key = cell_key[i+1];
    end

    stsd_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_entry (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (cell_live[i]),
      .key_bcast (key_bcast),
      .left_key  (left_key),
      .left_le   (left_le),
      .right_key (right_key),
      .key_o     (cell_key[i]),
      .le_o      (cell_le[i]),
      .eq_o      (cell_eq[i])
    );
  end

  // controller next state, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_code_nxt  = out_code_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_LOAD) begin
            if (full) begin
              out_code_nxt = RC_FULL;
            end else begin
              out_code_nxt = RC_NOT_FOUND;
              count_nxt    = count_r + CW'(1);
            end
          end else if (hit) begin
            count_nxt    = count_r - CW'(1);
            out_code_nxt = (count_r == CW'(1)) ? RC_NOW_EMPTY : RC_DELETED;
          end else begin
            out_code_nxt = RC_NOT_FOUND;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tdata[0];
      key_r <= in_key;
    end
    if (done) begin
      out_code_r  <= out_code_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_count_r, out_code_r});

endmodule

`default_nettype wire

// ----- hw/rtl/stsd_cell.sv -----
// one entry of the sorted key row: holds a key and its compare flags
// depends on stsd_pkg; neighbors exchange keys and the le flag
`default_nettype none

module stsd_cell
  import stsd_pkg::*;
#(
  parameter int KEY_WIDTH = 18
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 live,       // entry lies below the count
  input  wire logic [KEY_WIDTH-1:0] key_bcast,  // key under search or insert
  input  wire logic [KEY_WIDTH-1:0] left_key,   // key of the lower neighbor
  input  wire logic                 left_le,    // lower neighbor stays put on insert
  input  wire logic [KEY_WIDTH-1:0] right_key,  // key of the upper neighbor
  output logic [KEY_WIDTH-1:0]      key_o,
  output logic                      le_o,
  output logic                      eq_o
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic                 le_r;
  logic                 lt_r;

  // compare flags, taken when the item is accepted
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      le_r <= live && (key_r <= key_bcast);
      lt_r <= live && (key_r < key_bcast);
    end
  end

  // insert moves larger keys up, delete pulls keys at or past the match down
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins_en && !le_r) begin
      key_nxt = left_le ? key_bcast : left_key;
    end else if (ctrl.del_en && !lt_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;
  assign le_o  = le_r;
  assign eq_o  = le_r && !lt_r;

endmodule

`default_nettype wire

// ----- tb/tb_sorted_table_search_delete.sv -----
// self-checking testbench for the sorted key table with search and delete
// drives load and query items, predicts each result item and compares them
// depends on stsd_pkg and sorted_table_search_delete
`timescale 1ns / 100ps

module tb_sorted_table_search_delete
  import stsd_pkg::*;
();

  localparam int DEPTH   = 1024;
  localparam int KEY_W   = 18;
  localparam int CNT_W   = 11;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 16;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // one expected result item
  typedef struct {
    logic [1:0]       code;
    logic [CNT_W-1:0] count;
  } table_reply_t;

  // shadow of the key table and the queue of awaited replies
  class key_table_scoreboard;
    logic [KEY_W-1:0] keys[DEPTH];
    int               live = 0;
    table_reply_t     pending_replies[$];
    int               errors = 0;
    int               n_loads = 0, n_queries = 0, n_hits = 0;
    int               n_emptied = 0, n_dropped = 0, n_checked = 0;

    // update the shadow table for an accepted item and queue its reply
    function void note_item(logic op, logic [KEY_W-1:0] key);
      table_reply_t r;
      int pos;
      int k;
      pos = 0;
      if (op == OP_LOAD) begin
        n_loads++;
        if (live >= DEPTH) begin
          r.code = RC_FULL;
          n_dropped++;
        end else begin
          // equal keys stay ahead of the new one
          while (pos < live && keys[pos] <= key) pos++;
          for (k = live; k > pos; k--) keys[k] = keys[k-1];
          keys[pos] = key;
          live++;
          r.code = RC_NOT_FOUND;
        end
      end else begin
        n_queries++;
        while (pos < live && keys[pos] != key) pos++;
        if (pos >= live) begin
          r.code = RC_NOT_FOUND;
        end else begin
          // close the gap over the first matching copy
          for (k = pos; k + 1 < live; k++) keys[k] = keys[k+1];
          live--;
          n_hits++;
          if (live == 0) begin
            r.code = RC_NOW_EMPTY;
            n_emptied++;
          end else begin
            r.code = RC_DELETED;
          end
        end
      end
      r.count = live[CNT_W-1:0];
      pending_replies.push_back(r);
    endfunction

    // compare one result item with the oldest awaited reply
    function void check_result(logic [1:0] code, logic [CNT_W-1:0] count);
      table_reply_t r;
      if (pending_replies.size() == 0) begin
        $error("result item with nothing awaited: result_code %0d live_count %0d",
               code, count);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      n_checked++;
      if (code !== r.code) begin
        $error("result_code mismatch: expected %0d, actual %0d", r.code, code);
        errors++;
      end
      if (count !== r.count) begin
        $error("live_count mismatch: expected %0d, actual %0d", r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // operation, key_value
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // result_code, live_count

  key_table_scoreboard sb;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  sorted_table_search_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random backpressure, changed at the falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = rst_n && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // check result items at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[1:0], out_tdata[CNT_W+1:2]);
  end

  // present one item, with random gaps ahead of it, and wait for acceptance
  task automatic send_item(logic op, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_W-KEY_W-1){1'b0}}, key, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, key);
    @(negedge clk);
  endtask

  // pick a key: extremes, a narrow pool for duplicates, or any value
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return KEY_MAX;
    if (sel <= 3) return KEY_W'($urandom_range(15));
    return KEY_W'($urandom_range(2**KEY_W - 1));
  endfunction

  // one random item; queries often target a key that is held
  task automatic send_random(int load_pct, int hit_pct);
    logic             op;
    logic [KEY_W-1:0] key;
    op  = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_QUERY;
    key = pick_key();
    if (op == OP_QUERY && sb.live > 0 && $urandom_range(99) < hit_pct)
      key = sb.keys[$urandom_range(sb.live - 1)];
    send_item(op, key);
  endtask

  // stimulus
  initial begin
    int guard;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, duplicates, drain to empty
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, KEY_MAX);
    send_item(OP_LOAD, KEY_MAX);
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, 18'h20000);
    send_item(OP_LOAD, 18'h15555);
    send_item(OP_LOAD, 18'h2aaaa);
    send_item(OP_QUERY, 18'd7);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, KEY_MAX);
    send_item(OP_QUERY, 18'h15555);
    send_item(OP_QUERY, 18'h2aaaa);
    send_item(OP_QUERY, 18'h20000);
    send_item(OP_QUERY, 18'h20000);
    repeat (3) send_item(OP_LOAD, 18'd42);
    repeat (3) send_item(OP_QUERY, 18'd42);

    // small table, frequent hits and empties
    in_idle_pct  = 32;
    out_idle_pct = 74;
    repeat (80) send_random(50, 70);

    // fill to the top, then push against the full table
    in_idle_pct  = 74;
    out_idle_pct = 32;
    while (sb.live < DEPTH) send_random(95, 50);
    repeat (40) send_random(60, 60);

    // no idling, mostly hitting queries
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (60) send_random(30, 80);
    in_tvalid = 1'b0;

    // let every awaited reply come back
    guard = 0;
    while (sb.pending_replies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending_replies.size() != 0) begin
      $error("%0d result items never arrived", sb.pending_replies.size());
      sb.errors++;
    end
    repeat (8) @(posedge clk);

    $display("ran %0d loads and %0d queries, %0d results checked",
             sb.n_loads, sb.n_queries, sb.n_checked);
    $display("hits %0d, emptied %0d times, %0d loads dropped on a full table",
             sb.n_hits, sb.n_emptied, sb.n_dropped);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
